>>> rtl/core/sscp_pkg.sv
// Shared constants, payload types and register codes for the scaled sprite pixel unit.
package sscp_pkg;

    // Screen and store geometry.
    localparam int STRIP_COLUMNS = 40;
    localparam int STRIP_ROWS    = 128;
    localparam int SCREEN_ROWS   = 128;
    localparam int STRIP_COUNT   = 4;
    localparam int TEXEL_DEPTH   = 4096;

    // Derived widths.
    localparam int TEX_AW  = $clog2(TEXEL_DEPTH);
    localparam int SH_MAX  = SCREEN_ROWS * 31 / 8;
    localparam int SH_W    = $clog2(SH_MAX + 1);
    localparam int SW_W    = SH_W + 7;
    localparam int REM_W   = SW_W + 7;
    localparam int TQ_W    = 7;
    localparam int CW      = SW_W + 3;
    localparam int TA_W    = 2 * TQ_W;
    localparam int PADDR_W = 5;

    // Item commands.
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_SHADE = 1'b1;

    // Register map, one word apart.
    typedef enum logic [2:0] {
        REG_PRESENT  = 3'd0,
        REG_WIDTH    = 3'd1,
        REG_HEIGHT   = 3'd2,
        REG_SCALE    = 3'd3,
        REG_ANCHOR_X = 3'd4,
        REG_ANCHOR_Y = 3'd5,
        REG_KEY      = 3'd6,
        REG_STRIP    = 3'd7
    } reg_index_t;

    typedef struct packed {
        logic        command;
        logic [11:0] texel_index;
        logic [15:0] texel_value;
        logic [7:0]  screen_col;
        logic [6:0]  screen_row;
    } pixel_in_t;

    typedef struct packed {
        logic        write_enable;
        logic [12:0] buffer_index;
        logic [15:0] pixel_word;
    } pixel_out_t;

    typedef struct packed {
        logic               sprite_present;
        logic [6:0]         sprite_width;
        logic [6:0]         sprite_height;
        logic [4:0]         scale_eighths;
        logic signed [9:0]  anchor_x;
        logic signed [9:0]  anchor_y;
        logic [15:0]        key_color;
        logic [1:0]         strip_select;
    } cfg_t;

endpackage

>>> rtl/core/sscp_regs.sv
// Configuration register bank behind the APB-style port.
module sscp_regs (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sscp_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output sscp_pkg::cfg_t              cfg
);

    sscp_pkg::cfg_t        cfg_reg;
    sscp_pkg::reg_index_t  idx;
    logic                  wr;

    assign pready = 1'b1;
    assign idx    = sscp_pkg::reg_index_t'(paddr[4:2]);
    assign wr     = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    // Register writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sprite_present <= 1'b0;
            cfg_reg.sprite_width   <= 7'd1;
            cfg_reg.sprite_height  <= 7'd1;
            cfg_reg.scale_eighths  <= 5'd8;
            cfg_reg.anchor_x       <= '0;
            cfg_reg.anchor_y       <= '0;
            cfg_reg.key_color      <= '0;
            cfg_reg.strip_select   <= '0;
        end else if (wr) begin
            unique case (idx)
                sscp_pkg::REG_PRESENT:  cfg_reg.sprite_present <= pwdata[0];
                sscp_pkg::REG_WIDTH:    cfg_reg.sprite_width   <= pwdata[6:0];
                sscp_pkg::REG_HEIGHT:   cfg_reg.sprite_height  <= pwdata[6:0];
                sscp_pkg::REG_SCALE:    cfg_reg.scale_eighths  <= pwdata[4:0];
                sscp_pkg::REG_ANCHOR_X: cfg_reg.anchor_x       <= $signed(pwdata[9:0]);
                sscp_pkg::REG_ANCHOR_Y: cfg_reg.anchor_y       <= $signed(pwdata[9:0]);
                sscp_pkg::REG_KEY:      cfg_reg.key_color      <= pwdata[15:0];
                sscp_pkg::REG_STRIP:    cfg_reg.strip_select   <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    // Read mux.
    always_comb begin
        prdata = '0;
        unique case (idx)
            sscp_pkg::REG_PRESENT:  prdata = 32'(cfg_reg.sprite_present);
            sscp_pkg::REG_WIDTH:    prdata = 32'(cfg_reg.sprite_width);
            sscp_pkg::REG_HEIGHT:   prdata = 32'(cfg_reg.sprite_height);
            sscp_pkg::REG_SCALE:    prdata = 32'(cfg_reg.scale_eighths);
            sscp_pkg::REG_ANCHOR_X: prdata = {22'd0, cfg_reg.anchor_x};
            sscp_pkg::REG_ANCHOR_Y: prdata = {22'd0, cfg_reg.anchor_y};
            sscp_pkg::REG_KEY:      prdata = 32'(cfg_reg.key_color);
            sscp_pkg::REG_STRIP:    prdata = 32'(cfg_reg.strip_select);
            default:                prdata = '0;
        endcase
    end

endmodule

>>> rtl/core/sscp_texel_ram.sv
// Texel store: one write port and one registered read port.
module sscp_texel_ram (
    input  logic                        aclk,
    input  logic                        rd_en,
    input  logic [sscp_pkg::TEX_AW-1:0] rd_addr,
    output logic [15:0]                 rd_data,
    input  logic                        wr_en,
    input  logic [sscp_pkg::TEX_AW-1:0] wr_addr,
    input  logic [15:0]                 wr_data
);

    logic [15:0] mem [sscp_pkg::TEXEL_DEPTH];

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, held while the pipeline stalls.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> rtl/core/scaled_sprite_colorkey_pixel_unit.sv
// Top level of the scaled sprite pixel unit: pipelined geometry, division and key test.
//
// Channel  Ports                         Payload               Role
// s_       s_valid s_ready s_data        pixel_in_t            load or shade item in
// m_       m_valid m_ready m_data        pixel_out_t           one strip buffer beat out
// apb      psel penable pwrite paddr ..  32-bit words          configuration registers
//
// One item enters per clock while the output is not stalled; every item leaves as exactly one beat, in order.
// The sprite width and the texel coordinates go through one-bit-per-stage dividers.
// The whole pipeline advances when the output register is empty or taken.
// Reset is synchronous; it clears only the valid bits and sets the configuration registers to defaults.
module scaled_sprite_colorkey_pixel_unit (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  sscp_pkg::pixel_in_t          s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output sscp_pkg::pixel_out_t         m_data,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [sscp_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    localparam int SW_W  = sscp_pkg::SW_W;
    localparam int SH_W  = sscp_pkg::SH_W;
    localparam int REM_W = sscp_pkg::REM_W;
    localparam int TQ_W  = sscp_pkg::TQ_W;
    localparam int CW    = sscp_pkg::CW;
    localparam int TA_W  = sscp_pkg::TA_W;
    localparam int LS    = SW_W - 1;
    localparam int LX    = TQ_W - 1;

    sscp_pkg::cfg_t cfg;
    logic           adv;
    logic           m_valid_reg;

    sscp_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The pipeline moves as one when the output register can take a beat.
    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;

    // Input stage.
    logic                v1_reg;
    sscp_pkg::pixel_in_t it1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            it1_reg <= s_data;
        end
    end

    // Scaled height and the numerator of the width division.
    logic [SH_W-1:0]     sh_c;
    logic                v2_reg;
    sscp_pkg::pixel_in_t it2_reg;
    logic [SH_W-1:0]     sh2_reg;
    logic [REM_W-1:0]    num2_reg;

    assign sh_c = SH_W'((sscp_pkg::SCREEN_ROWS * int'(cfg.scale_eighths)) >> 3);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (adv) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            it2_reg  <= it1_reg;
            sh2_reg  <= sh_c;
            num2_reg <= REM_W'(sh_c) * REM_W'(cfg.sprite_width);
        end
    end

    // Width division: one quotient bit per stage, most significant first.
    logic                dv_v_reg   [SW_W];
    sscp_pkg::pixel_in_t dv_it_reg  [SW_W];
    logic [SH_W-1:0]     dv_sh_reg  [SW_W];
    logic [REM_W-1:0]    dv_rem_reg [SW_W];
    logic [SW_W-1:0]     dv_q_reg   [SW_W];

    for (genvar k = 0; k < SW_W; k++) begin : g_sw_div
        logic                vi;
        sscp_pkg::pixel_in_t iti;
        logic [SH_W-1:0]     shi;
        logic [REM_W-1:0]    remi;
        logic [SW_W-1:0]     qi;
        logic [REM_W-1:0]    dsh;
        logic                ge;

        if (k == 0) begin : g_first
            assign vi   = v2_reg;
            assign iti  = it2_reg;
            assign shi  = sh2_reg;
            assign remi = num2_reg;
            assign qi   = '0;
        end else begin : g_next
            assign vi   = dv_v_reg[k-1];
            assign iti  = dv_it_reg[k-1];
            assign shi  = dv_sh_reg[k-1];
            assign remi = dv_rem_reg[k-1];
            assign qi   = dv_q_reg[k-1];
        end

        assign dsh = REM_W'(cfg.sprite_height) << (SW_W - 1 - k);
        assign ge  = remi >= dsh;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_v_reg[k] <= 1'b0;
            end else if (adv) begin
                dv_v_reg[k] <= vi;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                dv_it_reg[k]  <= iti;
                dv_sh_reg[k]  <= shi;
                dv_rem_reg[k] <= ge ? remi - dsh : remi;
                dv_q_reg[k]   <= qi | (SW_W'(ge) << (SW_W - 1 - k));
            end
        end
    end

    // Placement: left and top edges, offsets into the sprite and the strip.
    logic signed [CW-1:0] left_c, top_c;
    logic                 vg1_reg;
    sscp_pkg::pixel_in_t  itg1_reg;
    logic [SH_W-1:0]      shg1_reg;
    logic [SW_W-1:0]      swg1_reg;
    logic signed [CW-1:0] dxs_reg, dys_reg, colrel_reg;

    assign left_c = CW'(cfg.anchor_x)
                    - $signed({{(CW-SW_W){1'b0}}, dv_q_reg[LS] >> 1});
    assign top_c  = CW'(cfg.anchor_y) - $signed({{(CW-SH_W){1'b0}}, dv_sh_reg[LS]});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vg1_reg <= 1'b0;
        end else if (adv) begin
            vg1_reg <= dv_v_reg[LS];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            itg1_reg   <= dv_it_reg[LS];
            shg1_reg   <= dv_sh_reg[LS];
            swg1_reg   <= dv_q_reg[LS];
            dxs_reg    <= $signed({{(CW-8){1'b0}}, dv_it_reg[LS].screen_col}) - left_c;
            dys_reg    <= $signed({{(CW-7){1'b0}}, dv_it_reg[LS].screen_row}) - top_c;
            colrel_reg <= $signed({{(CW-8){1'b0}}, dv_it_reg[LS].screen_col})
                          - CW'(sscp_pkg::STRIP_COLUMNS * int'(cfg.strip_select));
        end
    end

    // Clipping tests and the numerators of the texel coordinate divisions.
    logic                 inside_c;
    logic                 vg2_reg;
    sscp_pkg::pixel_in_t  itg2_reg;
    logic                 insg2_reg;
    logic [SH_W-1:0]      shg2_reg;
    logic [SW_W-1:0]      swg2_reg;
    logic [12:0]          bidxg2_reg;
    logic [REM_W-1:0]     numx_reg, numy_reg;

    always_comb begin
        inside_c = itg1_reg.command == sscp_pkg::CMD_SHADE
                   && cfg.sprite_present
                   && cfg.sprite_width != '0 && cfg.sprite_height != '0
                   && int'(cfg.strip_select) < sscp_pkg::STRIP_COUNT
                   && shg1_reg != '0 && swg1_reg != '0
                   && !dxs_reg[CW-1]
                   && dxs_reg < $signed({{(CW-SW_W){1'b0}}, swg1_reg})
                   && !dys_reg[CW-1]
                   && dys_reg < $signed({{(CW-SH_W){1'b0}}, shg1_reg})
                   && !colrel_reg[CW-1]
                   && colrel_reg < CW'(sscp_pkg::STRIP_COLUMNS)
                   && int'(itg1_reg.screen_row) < sscp_pkg::SCREEN_ROWS
                   && int'(itg1_reg.screen_row) < sscp_pkg::STRIP_ROWS;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vg2_reg <= 1'b0;
        end else if (adv) begin
            vg2_reg <= vg1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            itg2_reg   <= itg1_reg;
            insg2_reg  <= inside_c;
            shg2_reg   <= shg1_reg;
            swg2_reg   <= swg1_reg;
            bidxg2_reg <= 13'(int'(itg1_reg.screen_row) * sscp_pkg::STRIP_COLUMNS)
                          + 13'(colrel_reg);
            numx_reg   <= inside_c ? REM_W'(dxs_reg[SW_W-1:0]) * REM_W'(cfg.sprite_width)
                                   : '0;
            numy_reg   <= inside_c ? REM_W'(dys_reg[SH_W-1:0]) * REM_W'(cfg.sprite_height)
                                   : '0;
        end
    end

    // Texel coordinate divisions, both axes side by side.
    logic                xv_v_reg    [TQ_W];
    sscp_pkg::pixel_in_t xv_it_reg   [TQ_W];
    logic                xv_ins_reg  [TQ_W];
    logic [12:0]         xv_bidx_reg [TQ_W];
    logic [SH_W-1:0]     xv_sh_reg   [TQ_W];
    logic [SW_W-1:0]     xv_sw_reg   [TQ_W];
    logic [REM_W-1:0]    xv_rx_reg   [TQ_W];
    logic [REM_W-1:0]    xv_ry_reg   [TQ_W];
    logic [TQ_W-1:0]     xv_qx_reg   [TQ_W];
    logic [TQ_W-1:0]     xv_qy_reg   [TQ_W];

    for (genvar j = 0; j < TQ_W; j++) begin : g_xy_div
        logic                vi;
        sscp_pkg::pixel_in_t iti;
        logic                insi;
        logic [12:0]         bidxi;
        logic [SH_W-1:0]     shi;
        logic [SW_W-1:0]     swi;
        logic [REM_W-1:0]    rxi, ryi, dx, dy;
        logic [TQ_W-1:0]     qxi, qyi;
        logic                gex, gey;

        if (j == 0) begin : g_first
            assign vi    = vg2_reg;
            assign iti   = itg2_reg;
            assign insi  = insg2_reg;
            assign bidxi = bidxg2_reg;
            assign shi   = shg2_reg;
            assign swi   = swg2_reg;
            assign rxi   = numx_reg;
            assign ryi   = numy_reg;
            assign qxi   = '0;
            assign qyi   = '0;
        end else begin : g_next
            assign vi    = xv_v_reg[j-1];
            assign iti   = xv_it_reg[j-1];
            assign insi  = xv_ins_reg[j-1];
            assign bidxi = xv_bidx_reg[j-1];
            assign shi   = xv_sh_reg[j-1];
            assign swi   = xv_sw_reg[j-1];
            assign rxi   = xv_rx_reg[j-1];
            assign ryi   = xv_ry_reg[j-1];
            assign qxi   = xv_qx_reg[j-1];
            assign qyi   = xv_qy_reg[j-1];
        end

        assign dx  = REM_W'(swi) << (TQ_W - 1 - j);
        assign dy  = REM_W'(shi) << (TQ_W - 1 - j);
        assign gex = rxi >= dx;
        assign gey = ryi >= dy;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                xv_v_reg[j] <= 1'b0;
            end else if (adv) begin
                xv_v_reg[j] <= vi;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                xv_it_reg[j]   <= iti;
                xv_ins_reg[j]  <= insi;
                xv_bidx_reg[j] <= bidxi;
                xv_sh_reg[j]   <= shi;
                xv_sw_reg[j]   <= swi;
                xv_rx_reg[j]   <= gex ? rxi - dx : rxi;
                xv_ry_reg[j]   <= gey ? ryi - dy : ryi;
                xv_qx_reg[j]   <= qxi | (TQ_W'(gex) << (TQ_W - 1 - j));
                xv_qy_reg[j]   <= qyi | (TQ_W'(gey) << (TQ_W - 1 - j));
            end
        end
    end

    // Texel address; loads write and shades read the store at this same point.
    logic [TA_W-1:0] taddr_c;
    logic            taddr_ok;
    logic            mem_we;
    logic [15:0]     mem_rd;
    logic            vA_reg;
    logic            weA_reg;
    logic [12:0]     bidxA_reg;

    assign taddr_c  = TA_W'(xv_qy_reg[LX]) * TA_W'(cfg.sprite_width) + TA_W'(xv_qx_reg[LX]);
    assign taddr_ok = int'(taddr_c) < sscp_pkg::TEXEL_DEPTH
                      && xv_qx_reg[LX] < cfg.sprite_width
                      && xv_qy_reg[LX] < cfg.sprite_height;
    assign mem_we   = xv_v_reg[LX] && adv
                      && xv_it_reg[LX].command == sscp_pkg::CMD_LOAD
                      && int'(xv_it_reg[LX].texel_index) < sscp_pkg::TEXEL_DEPTH;

    sscp_texel_ram u_ram (
        .aclk    (aclk),
        .rd_en   (adv),
        .rd_addr (sscp_pkg::TEX_AW'(taddr_c)),
        .rd_data (mem_rd),
        .wr_en   (mem_we),
        .wr_addr (sscp_pkg::TEX_AW'(xv_it_reg[LX].texel_index)),
        .wr_data (xv_it_reg[LX].texel_value)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vA_reg <= 1'b0;
        end else if (adv) begin
            vA_reg <= xv_v_reg[LX];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            weA_reg   <= xv_ins_reg[LX] && taddr_ok;
            bidxA_reg <= xv_bidx_reg[LX];
        end
    end

    // Color key test, byte swap and the output register.
    logic                 hit_c;
    sscp_pkg::pixel_out_t out_next;
    sscp_pkg::pixel_out_t m_data_reg;

    always_comb begin
        hit_c                 = weA_reg && mem_rd != cfg.key_color;
        out_next.write_enable = hit_c;
        out_next.buffer_index = hit_c ? bidxA_reg : '0;
        out_next.pixel_word   = hit_c ? {mem_rd[7:0], mem_rd[15:8]} : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= vA_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_data_reg <= out_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // A beat without a write carries a zero address and word.
    a_nowrite_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.write_enable)
            |-> (m_data.buffer_index == '0 && m_data.pixel_word == '0))
        else $error("non-write beat carries a nonzero address or word");

    // The last pipeline stage holds its item while the output is stalled.
    a_stage_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (vA_reg && !adv) |=> (vA_reg && $stable(bidxA_reg) && $stable(weA_reg)))
        else $error("texel stage changed during a stall");

    // A freshly loaded write beat always comes from an item that passed the clipping tests.
    a_write_source: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.write_enable && $past(adv)) |-> $past(weA_reg))
        else $error("write beat without a clipped-in texel");

endmodule
